>>> rtl/ddfp_pkg.sv
// Shared types and constants for the delimited decimal field parser.
// Holds the classified byte record passed from the front to the back part.
// No dependencies.
package ddfp_pkg;

    localparam int CFG_WIDTH = 64;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int VALUE_WIDTH = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DELIM_MAP_LOW  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DELIM_MAP_HIGH = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPACE_MAP      = 2'd2;

    localparam logic [CFG_WIDTH-1:0] DELIM_MAP_LOW_RESET  = 64'h0000_0001_0000_2400;
    localparam logic [CFG_WIDTH-1:0] DELIM_MAP_HIGH_RESET = 64'h0;
    localparam logic [CFG_WIDTH-1:0] SPACE_MAP_RESET      = 64'h0000_0001_0000_2400;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [VALUE_WIDTH-1:0] RADIX = 32'd10;

    typedef struct packed {
        logic       delim;
        logic       space;
        logic       digit;
        logic       minus;
        logic       plus;
        logic       last;
        logic [3:0] digit_value;
    } byte_class_t;

endpackage

>>> rtl/ddfp_front.sv
// Front part: holds the delimiter and space maps and classifies each text byte.
// Depends on ddfp_pkg.
module ddfp_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ddfp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [ddfp_pkg::CFG_WIDTH-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          text_byte,
    input  logic                                end_of_buffer,
    output logic                                push_valid,
    input  logic                                push_ready,
    output ddfp_pkg::byte_class_t               push_data
);

    logic [ddfp_pkg::CFG_WIDTH-1:0] delim_low_reg;
    logic [ddfp_pkg::CFG_WIDTH-1:0] delim_high_reg;
    logic [ddfp_pkg::CFG_WIDTH-1:0] space_map_reg;
    logic [7:0]                     offset;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_low_reg  <= ddfp_pkg::DELIM_MAP_LOW_RESET;
            delim_high_reg <= ddfp_pkg::DELIM_MAP_HIGH_RESET;
            space_map_reg  <= ddfp_pkg::SPACE_MAP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ddfp_pkg::REG_DELIM_MAP_LOW:  delim_low_reg  <= cfg_data;
                ddfp_pkg::REG_DELIM_MAP_HIGH: delim_high_reg <= cfg_data;
                ddfp_pkg::REG_SPACE_MAP:      space_map_reg  <= cfg_data;
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        offset = text_byte - ddfp_pkg::CHAR_ZERO;
        push_data.delim = 1'b0;
        case (text_byte[7:6])
            2'b00:   push_data.delim = delim_low_reg[text_byte[5:0]];
            2'b01:   push_data.delim = delim_high_reg[text_byte[5:0]];
            default: push_data.delim = 1'b0;
        endcase
        push_data.space = (text_byte[7:6] == 2'b00) && space_map_reg[text_byte[5:0]];
        push_data.digit = (text_byte >= ddfp_pkg::CHAR_ZERO)
                       && (text_byte <= ddfp_pkg::CHAR_NINE);
        push_data.minus = (text_byte == ddfp_pkg::CHAR_MINUS);
        push_data.plus  = (text_byte == ddfp_pkg::CHAR_PLUS);
        push_data.last  = end_of_buffer;
        push_data.digit_value = offset[3:0];
    end

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

endmodule

>>> rtl/ddfp_queue.sv
// Short queue of classified bytes between the front and back parts.
// Depends on ddfp_pkg.
module ddfp_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  ddfp_pkg::byte_class_t push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output ddfp_pkg::byte_class_t pop_data
);

    localparam int PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
    localparam logic [PTR_WIDTH-1:0]   LAST_PTR  = PTR_WIDTH'(DEPTH - 1);
    localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(DEPTH);

    ddfp_pkg::byte_class_t      entry_reg [DEPTH];
    logic [PTR_WIDTH-1:0]       wr_ptr_reg;
    logic [PTR_WIDTH-1:0]       wr_ptr_next;
    logic [PTR_WIDTH-1:0]       rd_ptr_reg;
    logic [PTR_WIDTH-1:0]       rd_ptr_next;
    logic [COUNT_WIDTH-1:0]     count_reg;
    logic [COUNT_WIDTH-1:0]     count_next;
    logic                       do_push;
    logic                       do_pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/ddfp_back.sv
// Back part: field state, decimal accumulation and the registered result stage.
// Depends on ddfp_pkg.
module ddfp_back
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   pop_valid,
    output logic                                   pop_ready,
    input  ddfp_pkg::byte_class_t                  pop_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [ddfp_pkg::VALUE_WIDTH-1:0] field_value,
    output logic                                   field_valid,
    output logic                                   buffer_done
);

    logic [ddfp_pkg::VALUE_WIDTH-1:0] acc_reg;
    logic [ddfp_pkg::VALUE_WIDTH-1:0] acc_next;
    logic                             neg_reg;
    logic                             neg_next;
    logic                             inside_reg;
    logic                             inside_next;
    logic                             content_reg;
    logic                             content_next;
    logic                             pending_reg;
    logic                             pending_next;
    logic                             stopped_reg;
    logic                             stopped_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [ddfp_pkg::VALUE_WIDTH-1:0] out_acc_reg;
    logic                             out_neg_reg;
    logic                             out_flag_reg;
    logic                             out_done_reg;
    logic [ddfp_pkg::VALUE_WIDTH-1:0] emit_acc;
    logic                             emit_neg;
    logic                             emit_flag;
    logic                             emit_done;
    logic                             emit;
    logic                             take;

    assign pop_ready = !out_valid_reg || out_ready;
    assign take      = pop_valid && pop_ready;

    always_comb
    begin
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        inside_next  = inside_reg;
        content_next = content_reg;
        pending_next = pending_reg;
        stopped_next = stopped_reg;
        emit         = 1'b0;
        emit_acc     = acc_reg;
        emit_neg     = neg_reg;
        emit_flag    = content_reg && !stopped_reg;
        emit_done    = pop_data.last;

        if (pop_data.delim)
        begin
            emit         = inside_reg;
            acc_next     = '0;
            neg_next     = 1'b0;
            inside_next  = 1'b0;
            content_next = 1'b0;
            pending_next = 1'b0;
            stopped_next = 1'b0;
        end
        else
        begin
            if (!inside_reg)
            begin
                acc_next     = '0;
                neg_next     = 1'b0;
                content_next = 1'b0;
                pending_next = 1'b0;
                stopped_next = 1'b0;
            end
            inside_next = 1'b1;
            if (pop_data.space)
            begin
                if (content_next)
                begin
                    pending_next = 1'b1;
                end
            end
            else
            begin
                if (pending_next)
                begin
                    stopped_next = 1'b1;
                    pending_next = 1'b0;
                end
                if (!content_next && (pop_data.minus || pop_data.plus))
                begin
                    content_next = 1'b1;
                    neg_next     = pop_data.minus;
                end
                else
                begin
                    content_next = 1'b1;
                    if (!stopped_next && pop_data.digit)
                    begin
                        acc_next = acc_next * ddfp_pkg::RADIX
                                 + {28'd0, pop_data.digit_value};
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                end
            end
            emit      = pop_data.last;
            emit_acc  = acc_next;
            emit_neg  = neg_next;
            emit_flag = content_next && !stopped_next;
            emit_done = 1'b1;
            if (pop_data.last)
            begin
                acc_next     = '0;
                neg_next     = 1'b0;
                inside_next  = 1'b0;
                content_next = 1'b0;
                pending_next = 1'b0;
                stopped_next = 1'b0;
            end
        end

        if (take && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            inside_reg    <= 1'b0;
            content_reg   <= 1'b0;
            pending_reg   <= 1'b0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                acc_reg     <= acc_next;
                neg_reg     <= neg_next;
                inside_reg  <= inside_next;
                content_reg <= content_next;
                pending_reg <= pending_next;
                stopped_reg <= stopped_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_acc_reg  <= emit_acc;
            out_neg_reg  <= emit_neg;
            out_flag_reg <= emit_flag;
            out_done_reg <= emit_done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign field_value = out_neg_reg ? -out_acc_reg : out_acc_reg;
    assign field_valid = out_flag_reg;
    assign buffer_done = out_done_reg;

endmodule

>>> rtl/delimited_decimal_field_parser_top.sv
// Top level of the delimited decimal field parser.
// Instantiates ddfp_front, ddfp_queue and ddfp_back; depends on ddfp_pkg.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_ready   text_byte, end_of_buffer
//   output    out_valid / out_ready field_value, field_valid, buffer_done
//   config    cfg_we (no wait)      cfg_index, cfg_data
//
// One byte is accepted every cycle while in_ready is high. The byte that ends a
// field passes the queue stage, and its result then the registered result stage.
// The multiply-add on the accumulator is done combinationally in the back part.
// Reset clears the field state, the queue and the result valid flag, and loads the
// default maps. A stalled output fills the queue, and then input ready drops.
module delimited_decimal_field_parser_top
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [ddfp_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [ddfp_pkg::CFG_WIDTH-1:0]           cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [7:0]                              text_byte,
    input  logic                                    end_of_buffer,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [ddfp_pkg::VALUE_WIDTH-1:0]  field_value,
    output logic                                    field_valid,
    output logic                                    buffer_done
);

    logic                  push_valid;
    logic                  push_ready;
    ddfp_pkg::byte_class_t push_data;
    logic                  pop_valid;
    logic                  pop_ready;
    ddfp_pkg::byte_class_t pop_data;

    ddfp_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .text_byte     (text_byte),
        .end_of_buffer (end_of_buffer),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    ddfp_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ddfp_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .field_value (field_value),
        .field_valid (field_valid),
        .buffer_done (buffer_done)
    );

endmodule
